// ===== rtl/core/i2cmts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Phase and bus action codes, status constants and shared record types.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_WDATA = 3'd3,
        PH_RDATA = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_ADDR  = 3'd2,
        ACT_DATA  = 3'd3,
        ACT_RACK  = 3'd4,
        ACT_RNACK = 3'd5,
        ACT_STOP  = 3'd6,
        ACT_CLEAR = 3'd7
    } action_t;

    localparam logic [7:0] ST_MASK        = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_W_ADDR_NACK = 8'h20;
    localparam logic [7:0] ST_LOST        = 8'h38;
    localparam logic [7:0] ST_R_ADDR_NACK = 8'h48;
    localparam logic [7:0] ST_W_DATA_ACK  = 8'h28;
    localparam logic       READ_BIT       = 1'b1;

    localparam int IN_W  = 48;
    localparam int OUT_W = 40;

    // fixed-width part of the transfer context
    typedef struct packed {
        phase_t     phase;
        logic       is_read;
        logic [6:0] target_address;
    } ctx_t;

    typedef struct packed {
        logic [15:0] bytes_moved;
        logic        comm_error;
        logic        transfer_done;
        logic [7:0]  read_data;
        logic        data_valid;
        logic [7:0]  bus_byte;
        action_t     bus_action;
    } result_t;

endpackage

// ===== rtl/core/i2cmts_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer step logic
// Decides the next bus action, result fields and next context for one item.
// ----------------------------------------------------------------------------
module i2cmts_step
    import i2cmts_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  mode,
    input  logic                  direction,
    input  logic [6:0]            slave_address,
    input  logic [15:0]           byte_total,
    input  logic [7:0]            bus_status,
    input  logic [7:0]            received_byte,
    input  logic [7:0]            write_byte,
    input  ctx_t                  ctx,
    input  logic [COUNT_BITS-1:0] count_goal,
    input  logic [COUNT_BITS-1:0] count_done,
    output ctx_t                  ctx_next,
    output logic [COUNT_BITS-1:0] count_goal_next,
    output logic [COUNT_BITS-1:0] count_done_next,
    output result_t               res
);

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    logic [7:0]            st;
    logic [COUNT_BITS-1:0] goal_in;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] inc2;
    logic [31:0]           inc_ext;
    logic [31:0]           cnt_ext;

    assign st      = bus_status & ST_MASK;
    assign goal_in = COUNT_BITS'(byte_total);
    assign inc     = count_done + ONE;
    assign inc2    = inc + ONE;
    assign inc_ext = 32'(inc);
    assign cnt_ext = 32'(count_done);

    always_comb begin
        ctx_next        = ctx;
        count_goal_next = count_goal;
        count_done_next = count_done;
        res             = '0;
        res.bus_action  = ACT_NONE;
        if (!mode) begin
            ctx_next.is_read        = direction;
            ctx_next.target_address = slave_address;
            count_goal_next         = goal_in;
            count_done_next         = '0;
            if (direction && (goal_in == '0)) begin
                res.transfer_done = 1'b1;
                res.comm_error    = 1'b1;
                ctx_next.phase    = PH_IDLE;
            end else begin
                res.bus_action = ACT_START;
                ctx_next.phase = PH_START;
            end
        end else begin
            case (ctx.phase)
                PH_START: begin
                    if (st != ST_START) begin
                        res.transfer_done = 1'b1;
                        res.comm_error    = 1'b1;
                        ctx_next.phase    = PH_IDLE;
                    end else begin
                        res.bus_action = ACT_ADDR;
                        res.bus_byte   = {ctx.target_address, ctx.is_read & READ_BIT};
                        ctx_next.phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (st == (ctx.is_read ? ST_R_ADDR_NACK : ST_W_ADDR_NACK)) begin
                        res.bus_action    = ACT_STOP;
                        res.transfer_done = 1'b1;
                        res.comm_error    = 1'b1;
                        ctx_next.phase    = PH_IDLE;
                    end else if (st == ST_LOST) begin
                        res.bus_action    = ACT_CLEAR;
                        res.transfer_done = 1'b1;
                        res.comm_error    = 1'b1;
                        ctx_next.phase    = PH_IDLE;
                    end else if (ctx.is_read) begin
                        res.bus_action = (count_goal == ONE) ? ACT_RNACK : ACT_RACK;
                        ctx_next.phase = PH_RDATA;
                    end else if (count_goal == '0) begin
                        res.bus_action    = ACT_STOP;
                        res.transfer_done = 1'b1;
                        ctx_next.phase    = PH_IDLE;
                    end else begin
                        res.bus_action = ACT_DATA;
                        res.bus_byte   = write_byte;
                        ctx_next.phase = PH_WDATA;
                    end
                end
                PH_WDATA: begin
                    if (st == ST_W_DATA_ACK) begin
                        count_done_next = inc;
                        if (inc == count_goal) begin
                            res.bus_action    = ACT_STOP;
                            res.transfer_done = 1'b1;
                            res.bytes_moved   = inc_ext[15:0];
                            ctx_next.phase    = PH_IDLE;
                        end else begin
                            res.bus_action = ACT_DATA;
                            res.bus_byte   = write_byte;
                        end
                    end else begin
                        res.bus_action    = ACT_STOP;
                        res.transfer_done = 1'b1;
                        res.bytes_moved   = cnt_ext[15:0];
                        ctx_next.phase    = PH_IDLE;
                    end
                end
                PH_RDATA: begin
                    res.data_valid  = 1'b1;
                    res.read_data   = received_byte;
                    count_done_next = inc;
                    if (inc == count_goal) begin
                        res.bus_action    = ACT_STOP;
                        res.transfer_done = 1'b1;
                        res.bytes_moved   = inc_ext[15:0];
                        ctx_next.phase    = PH_IDLE;
                    end else begin
                        res.bus_action = (inc2 == count_goal) ? ACT_RNACK : ACT_RACK;
                    end
                end
                default: begin
                    ctx_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/i2cmts_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer result register
// Holds one result transaction and forwards downstream ready upstream.
// ----------------------------------------------------------------------------
module i2cmts_out
    import i2cmts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  result_t          res,
    output logic             load_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;

    assign load_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            data_reg <= OUT_W'(res);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== rtl/core/i2c_master_transfer_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Sequences one I2C master transfer over a byte-level bus engine.
// ----------------------------------------------------------------------------
// Each input transaction (a begin item or a bus status event) yields exactly
// one result transaction, registered in the cycle after acceptance. One item is
// taken every cycle while the result register is empty or being drained; the
// single result register and the combinational step logic set that rate.
module i2c_master_transfer_sequencer_top
    import i2cmts_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // direction[0], slave_address[7:1], byte_total[23:8], bus_status[31:24],
    // received_byte[39:32], write_byte[47:40]
    input  logic [IN_W-1:0]  s_tdata,
    // mode[0]
    input  logic [0:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // bus_action[2:0], bus_byte[10:3], data_valid[11], read_data[19:12],
    // transfer_done[20], comm_error[21], bytes_moved[37:22], zero[39:38]
    output logic [OUT_W-1:0] m_tdata
);

    ctx_t                  ctx_reg;
    ctx_t                  ctx_next;
    logic [COUNT_BITS-1:0] goal_reg;
    logic [COUNT_BITS-1:0] goal_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    result_t               res;
    logic                  accept;

    assign accept = s_tvalid && s_tready;

    i2cmts_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .mode            (s_tuser[0]),
        .direction       (s_tdata[0]),
        .slave_address   (s_tdata[7:1]),
        .byte_total      (s_tdata[23:8]),
        .bus_status      (s_tdata[31:24]),
        .received_byte   (s_tdata[39:32]),
        .write_byte      (s_tdata[47:40]),
        .ctx             (ctx_reg),
        .count_goal      (goal_reg),
        .count_done      (cnt_reg),
        .ctx_next        (ctx_next),
        .count_goal_next (goal_next),
        .count_done_next (cnt_next),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.phase          <= PH_IDLE;
            ctx_reg.is_read        <= 1'b0;
            ctx_reg.target_address <= '0;
            goal_reg               <= '0;
            cnt_reg                <= '0;
        end else if (accept) begin
            ctx_reg  <= ctx_next;
            goal_reg <= goal_next;
            cnt_reg  <= cnt_next;
        end
    end

    i2cmts_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_tvalid),
        .res        (res),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTH
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.transfer_done |=> ctx_reg.phase == PH_IDLE)
        else $error("finished transfer did not return to idle");

    a_error_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[20] && (m_tdata[37:22] == 16'd0))
        else $error("error result with byte count or without done");
`endif

endmodule
